// ----- rtl/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: shared package
// Widths, register codes, reset values and the types shared by the front end,
// the job queue and the arithmetic back end.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = 11;
    localparam int MAG_W     = 8;
    localparam int DIM_MIN   = 3;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic [POS_W-1:0] centre_col;
        logic [POS_W-1:0] centre_row;
        logic             frame_last;
    } t_meta;

    typedef struct packed {
        t_win  win;
        t_meta meta;
    } t_job;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

endpackage

// ----- rtl/sem_pix_if.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: pixel channel
// Valid/ready channel carrying one gray pixel word and its frame start flag.
// ----------------------------------------------------------------------------
interface sem_pix_if;
    logic                     valid;
    logic                     ready;
    logic [sem_pkg::PIX_W-1:0] pixel;
    logic                     frame_start;

    modport source (output valid, pixel, frame_start, input ready);
    modport sink   (input valid, pixel, frame_start, output ready);
endinterface

// ----- rtl/sem_res_if.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: result channel
// Valid/ready channel carrying one edge magnitude word with its position.
// ----------------------------------------------------------------------------
interface sem_res_if;
    logic                      valid;
    logic                      ready;
    logic [sem_pkg::MAG_W-1:0] edge_magnitude;
    logic [sem_pkg::POS_W-1:0] centre_col;
    logic [sem_pkg::POS_W-1:0] centre_row;
    logic                      frame_last;

    modport source (output valid, edge_magnitude, centre_col, centre_row, frame_last,
                    input ready);
    modport sink   (input valid, edge_magnitude, centre_col, centre_row, frame_last,
                    output ready);
endinterface

// ----- rtl/sobel_edge_magnitude_top.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: top level
// 3x3 Sobel gradient magnitude over a raster stream of 8-bit gray pixels.
//
// i_pix carries one pixel word per handshake, in raster order; frame_start
// puts that pixel at column 0, row 0. Frames also wrap on their own after
// frame_height rows of line_width pixels. o_res carries one word for every
// pixel whose 3x3 window lies fully inside the frame: the magnitude
// (saturated to 255), the window centre column and row, and a flag on the
// last word of the frame. Border pixels give no word.
// The configuration port writes line_width (index 0) and frame_height
// (index 1); write only while the block is idle.
// Throughput: one pixel word per cycle while o_res accepts results, set by one
// line buffer read and one line buffer write per pixel on separate memory ports
// and the fully pipelined back end.
// Path to o_res: input register, job queue, kernel, square-sum and root stages.
// Reset returns to 640 x 480, position zero and empty pipelines; line
// buffers are not cleared. When o_res stalls, the back end holds, the job
// queue fills, and then i_pix.ready drops.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sem_pix_if.sink                       i_pix,
    sem_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sem_pkg::CFG_W-1:0]     i_cfg_data
);

    sem_pkg::t_cfg_wr cfg;
    sem_pkg::t_job    job_in;
    sem_pkg::t_job    job_out;
    sem_pkg::t_q_ctl  q_ctl;
    sem_pkg::t_q_sts  q_sts;
    logic             push;
    logic             pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .o_job   (job_in),
        .o_push  (push),
        .i_full  (q_sts.full)
    );

    sem_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_data  (job_in),
        .o_data  (job_out),
        .o_sts   (q_sts)
    );

    sem_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_out),
        .i_empty (q_sts.empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ----- rtl/sem_front.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: front end
// Accepts pixel words, tracks raster position, keeps the two line buffers in
// one dual-row memory and the 3x3 window, and queues interior windows.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sem_pkg::t_cfg_wr i_cfg,
    sem_pix_if.sink          i_pix,
    output sem_pkg::t_job    o_job,
    output logic             o_push,
    input  logic             i_full
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int LB_W  = 2 * sem_pkg::PIX_W;
    localparam int W_RST = (int'(sem_pkg::LINE_WIDTH_RST) > MAX_WIDTH) ?
                           MAX_WIDTH : int'(sem_pkg::LINE_WIDTH_RST);
    localparam int H_RST = (int'(sem_pkg::FRAME_HEIGHT_RST) > MAX_HEIGHT) ?
                           MAX_HEIGHT : int'(sem_pkg::FRAME_HEIGHT_RST);

    function automatic logic [WB-1:0] clamp_w(input logic [sem_pkg::CFG_W-1:0] v);
        logic [WB-1:0] r;
        if (int'(v) < sem_pkg::DIM_MIN) begin
            r = WB'(sem_pkg::DIM_MIN);
        end else if (int'(v) > MAX_WIDTH) begin
            r = WB'(MAX_WIDTH);
        end else begin
            r = WB'(v);
        end
        return r;
    endfunction

    function automatic logic [HB-1:0] clamp_h(input logic [sem_pkg::CFG_W-1:0] v);
        logic [HB-1:0] r;
        if (int'(v) < sem_pkg::DIM_MIN) begin
            r = HB'(sem_pkg::DIM_MIN);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = HB'(MAX_HEIGHT);
        end else begin
            r = HB'(v);
        end
        return r;
    endfunction

    logic [WB-1:0] r_w;
    logic [HB-1:0] r_h;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic                      r_s1_valid;
    logic [sem_pkg::PIX_W-1:0] r_s1_px;
    logic [CW-1:0]             r_s1_col;
    logic                      r_s1_prod;
    sem_pkg::t_meta            r_s1_meta;
    logic                      r_fwd_hit;
    logic [LB_W-1:0]           r_fwd_data;
    logic [LB_W-1:0]           r_rd;
    logic [LB_W-1:0]           r_lb [MAX_WIDTH];
    sem_pkg::t_win             r_win, n_win;

    logic                      accept;
    logic                      s1_done;
    logic [WB-1:0]             c0, c1, col_p1;
    logic [HB-1:0]             r0, r1, row_p1;
    logic [CW-1:0]             col;
    logic [RW-1:0]             row;
    logic                      prod;
    logic                      last;
    logic [LB_W-1:0]           ab_eff;
    logic [LB_W-1:0]           wr_data;

    assign s1_done     = r_s1_valid && (!r_s1_prod || !i_full);
    assign i_pix.ready = !r_s1_valid || s1_done;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        c0 = i_pix.frame_start ? '0 : WB'(r_col);
        r0 = i_pix.frame_start ? '0 : HB'(r_row);
        if (c0 >= r_w) begin
            c1 = '0;
            r1 = r0 + 1'b1;
        end else begin
            c1 = c0;
            r1 = r0;
        end
        col    = CW'(c1);
        row    = (r1 >= r_h) ? '0 : RW'(r1);
        col_p1 = WB'(col) + 1'b1;
        row_p1 = HB'(row) + 1'b1;
        if (col_p1 >= r_w) begin
            n_col = '0;
            n_row = (row_p1 >= r_h) ? '0 : RW'(row_p1);
        end else begin
            n_col = CW'(col_p1);
            n_row = row;
        end
        prod = (col >= CW'(2)) && (row >= RW'(2));
        last = (WB'(col) == r_w - 1'b1) && (HB'(row) == r_h - 1'b1);
    end

    assign ab_eff  = r_fwd_hit ? r_fwd_data : r_rd;
    assign wr_data = {ab_eff[sem_pkg::PIX_W-1:0], r_s1_px};

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = ab_eff[LB_W-1:sem_pkg::PIX_W];
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = ab_eff[sem_pkg::PIX_W-1:0];
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_px;
    end

    assign o_job.win  = n_win;
    assign o_job.meta = r_s1_meta;
    assign o_push     = s1_done && r_s1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= WB'(W_RST);
            r_h        <= HB'(H_RST);
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    sem_pkg::CFG_LINE_WIDTH:   r_w <= clamp_w(i_cfg.data);
                    sem_pkg::CFG_FRAME_HEIGHT: r_h <= clamp_h(i_cfg.data);
                    default: ;
                endcase
            end
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_done) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px              <= i_pix.pixel;
            r_s1_col             <= col;
            r_s1_prod            <= prod;
            r_s1_meta.centre_col <= sem_pkg::POS_W'(CW'(col - 1'b1));
            r_s1_meta.centre_row <= sem_pkg::POS_W'(RW'(row - 1'b1));
            r_s1_meta.frame_last <= last;
            r_fwd_hit            <= s1_done && (r_s1_col == col);
            r_fwd_data           <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_lb[r_s1_col] <= wr_data;
        end
        if (accept) begin
            r_rd <= r_lb[col];
        end
    end

endmodule

// ----- rtl/sem_fifo.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: job queue
// Short register queue of window jobs between the front end and back end.
// ----------------------------------------------------------------------------
module sem_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sem_pkg::t_q_ctl i_ctl,
    input  sem_pkg::t_job   i_data,
    output sem_pkg::t_job   o_data,
    output sem_pkg::t_q_sts o_sts
);

    localparam int PW = $clog2(sem_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(sem_pkg::QUEUE_DEPTH + 1);

    sem_pkg::t_job r_q [sem_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;

    assign o_data      = r_q[r_rd_ptr];
    assign o_sts.full  = (r_count == NW'(sem_pkg::QUEUE_DEPTH));
    assign o_sts.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_ctl.pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_ctl.push, i_ctl.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/sem_back.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: back end
// Pipelined kernel sums, squares and an eight-stage digit-by-digit square
// root; the last stage register drives the result channel.
// ----------------------------------------------------------------------------
module sem_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sem_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    sem_res_if.source     o_res
);

    localparam int NST = 8;

    typedef struct packed {
        logic [15:0]    rad;
        logic [8:0]     rem;
        logic [7:0]     root;
        sem_pkg::t_meta meta;
    } t_rt;

    function automatic logic signed [10:0] sx(input logic [sem_pkg::PIX_W-1:0] v);
        return $signed({3'b000, v});
    endfunction

    function automatic t_rt sqrt_step(input t_rt x);
        t_rt         y;
        logic [10:0] rs;
        logic [10:0] tr;
        rs     = {x.rem, x.rad[15:14]};
        tr     = {1'b0, x.root, 2'b01};
        y      = x;
        y.rad  = {x.rad[13:0], 2'b00};
        if (rs >= tr) begin
            y.rem  = 9'(rs - tr);
            y.root = {x.root[6:0], 1'b1};
        end else begin
            y.rem  = 9'(rs);
            y.root = {x.root[6:0], 1'b0};
        end
        return y;
    endfunction

    logic                en;
    sem_pkg::t_win       p;
    logic signed [10:0]  gx, gy;
    logic [10:0]         abs_x, abs_y;

    logic                r_a_vld;
    logic [7:0]          r_a_ax, r_a_ay;
    sem_pkg::t_meta      r_a_meta;

    logic [15:0]         sq_x, sq_y;
    logic                r_b_vld;
    logic [16:0]         r_b_sum;
    sem_pkg::t_meta      r_b_meta;

    t_rt                 st_init;
    t_rt                 r_st [NST];
    t_rt                 n_st [NST];
    logic [NST-1:0]      r_vld;

    assign en    = !r_vld[NST-1] || o_res.ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        p     = i_job.win;
        gx    = sx(p[0]) - sx(p[2]) + ((sx(p[3]) - sx(p[5])) <<< 1) + sx(p[6]) - sx(p[8]);
        gy    = sx(p[6]) + (sx(p[7]) <<< 1) + sx(p[8]) - sx(p[0]) - (sx(p[1]) <<< 1)
                - sx(p[2]);
        abs_x = gx[10] ? 11'(-gx) : 11'(gx);
        abs_y = gy[10] ? 11'(-gy) : 11'(gy);
    end

    assign sq_x = 16'(r_a_ax) * 16'(r_a_ax);
    assign sq_y = 16'(r_a_ay) * 16'(r_a_ay);

    always_comb begin
        st_init.rad  = r_b_sum[16] ? 16'hFFFF : r_b_sum[15:0];
        st_init.rem  = '0;
        st_init.root = '0;
        st_init.meta = r_b_meta;
        n_st[0]      = sqrt_step(st_init);
        for (int k = 1; k < NST; k++) begin
            n_st[k] = sqrt_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_vld   <= '0;
        end else if (en) begin
            r_a_vld <= !i_empty;
            r_b_vld <= r_a_vld;
            r_vld   <= {r_vld[NST-2:0], r_b_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ax   <= abs_x[9:2];
            r_a_ay   <= abs_y[9:2];
            r_a_meta <= i_job.meta;
            r_b_sum  <= {1'b0, sq_x} + {1'b0, sq_y};
            r_b_meta <= r_a_meta;
            r_st     <= n_st;
        end
    end

    assign o_res.valid          = r_vld[NST-1];
    assign o_res.edge_magnitude = r_st[NST-1].root;
    assign o_res.centre_col     = r_st[NST-1].meta.centre_col;
    assign o_res.centre_row     = r_st[NST-1].meta.centre_row;
    assign o_res.frame_last     = r_st[NST-1].meta.frame_last;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude: self-checking testbench
// Streams gray pixel words into the block under a range of line and frame
// settings and checks every edge word against a cycle-free predictor of the
// 3x3 Sobel magnitude, position and end-of-frame flag, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 14;
    localparam int PHASE_PIXELS  = 70;

    typedef struct packed {
        logic [sem_pkg::MAG_W-1:0] magnitude;
        logic [sem_pkg::POS_W-1:0] col;
        logic [sem_pkg::POS_W-1:0] row;
        logic                      last;
    } t_edge_word;

    class magnitude_board;
        bit [sem_pkg::CFG_W-1:0] width_reg;
        bit [sem_pkg::CFG_W-1:0] height_reg;
        bit [sem_pkg::PIX_W-1:0] two_up [sem_pkg::MAX_WIDTH_DEF];
        bit [sem_pkg::PIX_W-1:0] one_up [sem_pkg::MAX_WIDTH_DEF];
        bit [sem_pkg::PIX_W-1:0] win [9];
        int unsigned             col_next;
        int unsigned             row_next;
        t_edge_word              edge_words_due [$];
        int unsigned             pixels_seen;
        int unsigned             words_checked;
        int unsigned             mismatches;

        function new();
            width_reg  = sem_pkg::LINE_WIDTH_RST;
            height_reg = sem_pkg::FRAME_HEIGHT_RST;
            col_next   = 0;
            row_next   = 0;
        endfunction

        function int unsigned pending();
            return edge_words_due.size();
        endfunction

        function void set_reg(bit [sem_pkg::CFG_IDX_W-1:0] idx,
                              bit [sem_pkg::CFG_W-1:0] data);
            if (idx == sem_pkg::CFG_LINE_WIDTH) width_reg = data;
            else if (idx == sem_pkg::CFG_FRAME_HEIGHT) height_reg = data;
        endfunction

        function int unsigned span(bit [sem_pkg::CFG_W-1:0] v, int unsigned top);
            if (v < sem_pkg::DIM_MIN) return sem_pkg::DIM_MIN;
            if (v > top) return top;
            return v;
        endfunction

        function int unsigned floor_root(int unsigned v);
            int unsigned root;
            int unsigned trial;
            root = 0;
            for (int b = 9; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        function void take_pixel(bit [sem_pkg::PIX_W-1:0] px, bit fs);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned root;
            int          gx;
            int          gy;
            t_edge_word  e;
            w = span(width_reg, sem_pkg::MAX_WIDTH_DEF);
            h = span(height_reg, sem_pkg::MAX_HEIGHT_DEF);
            pixels_seen++;
            if (fs) begin
                col_next = 0;
                row_next = 0;
            end
            if (col_next >= w) begin
                col_next = 0;
                row_next++;
            end
            if (row_next >= h) row_next = 0;
            c = col_next;
            r = row_next;
            for (int k = 0; k < 3; k++) begin
                win[3*k]   = win[3*k+1];
                win[3*k+1] = win[3*k+2];
            end
            win[2] = two_up[c];
            win[5] = one_up[c];
            win[8] = px;
            two_up[c] = one_up[c];
            one_up[c] = px;
            if (c >= 2 && r >= 2) begin
                gx = (int'(win[0]) - int'(win[2]) + 2 * (int'(win[3]) - int'(win[5]))
                      + int'(win[6]) - int'(win[8])) / 4;
                gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8])
                      - int'(win[0]) - 2 * int'(win[1]) - int'(win[2])) / 4;
                root = floor_root(gx * gx + gy * gy);
                e.magnitude = (root > 255) ? 8'd255 : sem_pkg::MAG_W'(root);
                e.col       = sem_pkg::POS_W'(c - 1);
                e.row       = sem_pkg::POS_W'(r - 1);
                e.last      = (c == w - 1) && (r == h - 1);
                edge_words_due.push_back(e);
            end
            if (c + 1 >= w) begin
                col_next = 0;
                row_next = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_next = c + 1;
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        task match_word(bit [sem_pkg::MAG_W-1:0] mag, bit [sem_pkg::POS_W-1:0] col,
                        bit [sem_pkg::POS_W-1:0] row, bit last);
            t_edge_word got;
            t_edge_word want;
            got = '{mag, col, row, last};
            if (edge_words_due.size() == 0) begin
                report($sformatf("unexpected word mag %0d col %0d row %0d last %0d",
                                 mag, col, row, last));
            end else begin
                want = edge_words_due.pop_front();
                words_checked++;
                if (got !== want)
                    report($sformatf("mag %0d/%0d col %0d/%0d row %0d/%0d last %0d/%0d",
                                     got.magnitude, want.magnitude, got.col, want.col,
                                     got.row, want.row, got.last, want.last));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                          i_cfg_we;
    logic [sem_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [sem_pkg::CFG_W-1:0]     i_cfg_data;

    sem_pix_if pix ();
    sem_res_if res ();

    sobel_edge_magnitude_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    magnitude_board board = new();
    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;
    bit          moved;
    int unsigned quiet    = 0;
    int unsigned settings = 0;

    bit [sem_pkg::PIX_W-1:0] shapes [27] = '{
        8'd255, 8'd0, 8'd0,  8'd255, 8'd0, 8'd0,  8'd255, 8'd255, 8'd255,
        8'd0,   8'd0, 8'd5,  8'd0,   8'd0, 8'd0,  8'd0,   8'd0,   8'd0,
        8'd0,   8'd0, 8'd255, 8'd0,  8'd0, 8'd255, 8'd0,  8'd0,   8'd255
    };

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_cfg_we) board.set_reg(i_cfg_idx, i_cfg_data);
            if (pix.valid && pix.ready) begin
                board.take_pixel(pix.pixel, pix.frame_start);
                moved = 1'b1;
            end
            if (res.valid && res.ready) begin
                board.match_word(res.edge_magnitude, res.centre_col, res.centre_row,
                                 res.frame_last);
                moved = 1'b1;
            end
            quiet = moved ? 0 : quiet + 1;
        end
    end

    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res.ready <= calm || ($urandom_range(99) >= 15);
            end
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet < QUIET_LIMIT);
        $display("Stalled for %0d cycles with %0d edge words outstanding",
                 quiet, board.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit [sem_pkg::PIX_W-1:0] draw_pixel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) return sem_pkg::PIX_W'($urandom_range(255));
        if (pick < 90) return $urandom_range(1) ? 8'd255 : 8'd0;
        return sem_pkg::PIX_W'($urandom_range(7));
    endfunction

    task automatic send_pixel(input bit [sem_pkg::PIX_W-1:0] px, input bit fs);
        while (!calm && $urandom_range(99) < 15) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel       <= px;
        pix.frame_start <= fs;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
    endtask

    task automatic stream(input int unsigned count, input bit first_fs,
                          input int unsigned break_pct);
        for (int unsigned n = 0; n < count; n++)
            send_pixel(draw_pixel(), (n == 0) ? first_fs : ($urandom_range(99) < break_pct));
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(input bit [sem_pkg::CFG_W-1:0] w,
                            input bit [sem_pkg::CFG_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sem_pkg::CFG_LINE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= sem_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings++;
    endtask

    initial begin
        bit [sem_pkg::CFG_W-1:0] w;
        bit [sem_pkg::CFG_W-1:0] h;
        int unsigned             pick;
        pix.valid       <= 1'b0;
        pix.pixel       <= '0;
        pix.frame_start <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= sem_pkg::CFG_LINE_WIDTH;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry, position zero without a frame start
        stream(40, 1'b0, 0);
        drain();

        // saturation, truncation toward zero, wrap without frame start
        set_dims(sem_pkg::CFG_W'(3), sem_pkg::CFG_W'(3));
        for (int i = 0; i < 27; i++) send_pixel(shapes[i], (i == 0) || (i == 18));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            pick = $urandom_range(99);
            w = (pick < 15) ? sem_pkg::CFG_W'($urandom_range(2))
                            : sem_pkg::CFG_W'($urandom_range(12, 3));
            pick = $urandom_range(99);
            if (pick < 10) h = sem_pkg::CFG_W'($urandom_range(2));
            else if (pick < 20) h = sem_pkg::CFG_W'($urandom_range(4095, 2049));
            else h = sem_pkg::CFG_W'($urandom_range(8, 3));
            calm = (ph >= PHASES - 4);
            set_dims(w, h);
            if (ph == 3) hold_req = 1'b1;
            stream(PHASE_PIXELS, 1'b1, 2);
            drain();
        end
        calm = 1'b0;

        $display("Sent %0d pixel words and checked %0d edge words over %0d geometries",
                 board.pixels_seen, board.words_checked, settings + 1);
        $display("Geometries spanned the reset size, small frames and clamped registers, %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ----- sobel_edge_magnitude_top.f -----
rtl/sem_pkg.sv
rtl/sem_pix_if.sv
rtl/sem_res_if.sv
rtl/sem_front.sv
rtl/sem_fifo.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude_top.sv
verif/testbench.sv
